// ----- hdl/cra_pkg.sv -----
package cra_pkg;

  localparam int WordW = 63;
  localparam int OutW  = 64;
  localparam int KW    = 15;
  localparam int OpW   = 2;
  localparam int LaneCount = 4;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef logic [WordW-1:0] word_t;
  typedef logic [OutW-1:0]  res_t;
  typedef logic [KW-1:0]    k_t;

  // Request: opcode plus one operand pair per lane
  typedef struct packed {
    logic [OpW-1:0] opcode;
    word_t          left0;
    word_t          left1;
    word_t          left2;
    word_t          left3;
    word_t          right0;
    word_t          right1;
    word_t          right2;
    word_t          right3;
  } req_t;

  typedef struct packed {
    res_t out0;
    res_t out1;
    res_t out2;
    res_t out3;
  } rsp_t;

  // Pipeline control travelling beside the lane data
  typedef struct packed {
    logic vld;
    op_t  op;
  } ctl_t;

endpackage

// ----- hdl/cra_mul32.sv -----
// Registered 32x32 partial product
module cra_mul32 (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ----- hdl/cra_lane.sv -----
// One residue lane, five pipeline stages
module cra_lane (
  input  logic               clk,
  input  cra_pkg::ctl_t      ctl_in,
  input  cra_pkg::word_t     a,
  input  cra_pkg::word_t     b,
  input  cra_pkg::k_t        k,
  output cra_pkg::res_t      res
);
  // stage 1: partial products of a*b, add/sub result
  logic [31:0] a0, a1, b0, b1;
  logic [63:0] p00, p01, p10, p11;
  cra_pkg::res_t as1;
  cra_pkg::ctl_t c1, c2, c3, c4;
  cra_pkg::k_t   k1, k2, k3, k4;
  logic [63:0]   s_as;

  assign a0 = a[31:0];
  assign a1 = {1'b0, a[62:32]};
  assign b0 = b[31:0];
  assign b1 = {1'b0, b[62:32]};

  cra_mul32 u_m00 (.clk(clk), .a(a0), .b(b0), .p(p00));
  cra_mul32 u_m01 (.clk(clk), .a(a0), .b(b1), .p(p01));
  cra_mul32 u_m10 (.clk(clk), .a(a1), .b(b0), .p(p10));
  cra_mul32 u_m11 (.clk(clk), .a(a1), .b(b1), .p(p11));

  always_comb begin
    if (ctl_in.op == cra_pkg::OP_ADD) begin
      s_as = {1'b0, a} + {1'b0, b};
    end else begin
      s_as = {1'b0, a} + ({1'b1, 63'd0} - {49'd0, k}) - {1'b0, b};
    end
  end

  always_ff @(posedge clk) begin
    c1  <= ctl_in;
    k1  <= k;
    as1 <= {1'b0, s_as[62:0]} + (s_as[63] ? {49'd0, k} : 64'd0);
  end

  // stage 2: assemble 126-bit product, split at 63
  logic [127:0] prod;
  logic [62:0]  u, l;
  cra_pkg::res_t as2;
  assign prod = {p11, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32);
  always_ff @(posedge clk) begin
    c2  <= c1;
    k2  <= k1;
    as2 <= as1;
    u   <= prod[125:63];
    l   <= prod[62:0];
  end

  // stage 3: q = u*k (63x15)
  logic [77:0] q;
  logic [62:0] l3;
  cra_pkg::res_t as3;
  always_ff @(posedge clk) begin
    c3  <= c2;
    k3  <= k2;
    as3 <= as2;
    l3  <= l;
    q   <= u * k2;
  end

  // stage 4: r = u2*k (15x15), first sum
  logic [29:0] r;
  logic [63:0] s1;
  cra_pkg::res_t as4;
  always_ff @(posedge clk) begin
    c4  <= c3;
    k4  <= k3;
    as4 <= as3;
    r   <= q[77:63] * k3;
    s1  <= {1'b0, l3} + {1'b0, q[62:0]};
  end

  // stage 5: final fold
  logic [63:0] s2;
  logic [2:0]  carry;
  always_comb begin
    s2    = {1'b0, s1[62:0]} + {34'd0, r};
    carry = {2'd0, s1[63]} + {2'd0, s2[63]};
  end

  always_ff @(posedge clk) begin
    unique case (c4.op)
      cra_pkg::OP_ADD, cra_pkg::OP_SUB: res <= as4;
      cra_pkg::OP_MUL: res <= {1'b0, s2[62:0]} + 64'(carry * k4);
      default:         res <= '0;
    endcase
  end
endmodule

// ----- hdl/crandall_residue_alu.sv -----
// Channel  | Ports                          | Notes
// request  | start, busy, req               | taken when start & !busy
// result   | done, rsp                      | one-cycle strobe
// config   | cfg_we, cfg_index, cfg_data    | immediate write
// Each request's result comes out of the lane pipeline with done; one request per cycle.
// The lane pipeline holds the multiply steps (a*b, u*k, fold).
// busy is always low; the receiver cannot stall, so nothing backs up.
// rst clears valid bits and sets every offset to 1.
module crandall_residue_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  cra_pkg::req_t              req,
  output logic                       done,
  output cra_pkg::rsp_t              rsp,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [cra_pkg::KW-1:0]     cfg_data
);
  localparam int NL = cra_pkg::LaneCount;
  localparam int Depth = 5;

  cra_pkg::k_t    kreg [NL];
  cra_pkg::word_t la [NL];
  cra_pkg::word_t rb [NL];
  cra_pkg::res_t  ro [NL];
  cra_pkg::ctl_t  ctl;
  logic [Depth-1:0] vpipe;

  assign busy = 1'b0;
  assign ctl.vld = start;
  assign ctl.op  = cra_pkg::op_t'(req.opcode);
  assign la[0] = req.left0;  assign la[1] = req.left1;
  assign la[2] = req.left2;  assign la[3] = req.left3;
  assign rb[0] = req.right0; assign rb[1] = req.right1;
  assign rb[2] = req.right2; assign rb[3] = req.right3;

  // offset registers; indices beyond the lane count are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NL; i++) kreg[i] <= cra_pkg::KW'(1);
    end else if (cfg_we && (32'(cfg_index) < NL)) begin
      kreg[cfg_index] <= cfg_data;
    end
  end

  // lanes
  for (genvar g = 0; g < NL; g++) begin : g_lane
    cra_lane u_lane (
      .clk(clk), .ctl_in(ctl), .a(la[g]), .b(rb[g]), .k(kreg[g]), .res(ro[g])
    );
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[Depth-2:0], start};
    end
  end

  // merge lanes into result
  assign done = vpipe[Depth-1];
  assign rsp.out0 = ro[0];
  assign rsp.out1 = ro[1];
  assign rsp.out2 = ro[2];
  assign rsp.out3 = ro[3];

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start |-> ##5 done) else $error("result strobe missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5)) else $error("unexpected result strobe");
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule
